FILE: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit allocator
// Header record layout, request kinds, status codes and beat structs.
// ----------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
    localparam int HEAP_BYTES   = 16384;
    localparam int HEADER_BYTES = 24;
    localparam int OFF_W        = $clog2(HEAP_BYTES);
    localparam int SIZE_W       = OFF_W;
    localparam int HDR_W        = SIZE_W + OFF_W + 2;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_FIT  = 3'd1,
        ST_ZERO    = 3'd2,
        ST_NULL    = 3'd3,
        ST_INVALID = 3'd4,
        ST_DOUBLE  = 3'd5
    } status_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  next;
        logic              next_valid;
        logic              free_mark;
    } hdr_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        request_bytes;
        logic               null_pointer;
        logic signed [31:0] pointer_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] payload_offset;
    } rsp_t;
endpackage
`default_nettype wire

FILE: rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/first_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core: first-fit heap allocator
// Free list of block headers kept in one header RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage: a request beat on s_ (init, allocate, free) yields exactly one
// response beat on m_ (status, payload offset). One request is worked at a
// time; s_ready is high only while the sequencer is idle and no response
// waits, so the next request can be taken in the cycle after the response
// beat is accepted. Init and rejected requests go straight to the response.
// An allocate reads each visited block of the free list in turn, then on a
// grant makes 1 to 3 header writes (split, predecessor link, granted header)
// before the response. A free reads the freed header, answers a double free
// if it is already free, else pushes it on the list and walks on from it,
// merging each adjacent successor, and answers when the walk ends.
// A stalled m_ready holds the response and s_ready low.
// Reset empties the free list (head invalid); the header RAM is not cleared
// and holds no meaning until init writes it.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_free_list_allocator_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ffa_pkg::req_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ffa_pkg::rsp_t      m_data
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_PREV, S_A_CUR,
        S_F_RD, S_F_CHK, S_W_RD, S_W_CHK, S_W_NRD, S_W_NCHK, S_RSP
    } state_t;

    localparam int STEP_W = OFF_W + 2;

    state_t            state_reg;
    logic [OFF_W-1:0]  head_reg;
    logic              head_valid_reg;
    logic [OFF_W-1:0]  cur_reg, prev_reg;
    logic              have_prev_reg;
    logic [15:0]       req_reg;
    hdr_t              cur_hdr_reg;
    hdr_t              prev_hdr_reg;
    logic [OFF_W-1:0]  succ_reg;
    logic              succ_valid_reg;
    logic [STEP_W-1:0] steps_reg;
    rsp_t              rsp_reg;

    logic              ram_we;
    logic [OFF_W-1:0]  ram_addr;
    hdr_t              ram_wdata, ram_rdata;

    ffa_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_BYTES)) u_hdr_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Address arithmetic on the request and the header just read
    logic signed [32:0] blk_off;
    logic [17:0]        split_at, need, end_at;
    logic [OFF_W:0]     merged;
    assign blk_off  = 33'(s_data.pointer_offset) - 33'(HEADER_BYTES);
    assign split_at = 18'(cur_reg) + 18'(HEADER_BYTES) + 18'(req_reg);
    assign need     = 18'(req_reg) + 18'(HEADER_BYTES) + 18'd1;
    assign end_at   = 18'(cur_reg) + 18'(HEADER_BYTES) + 18'(cur_hdr_reg.size);
    assign merged   = (OFF_W+1)'(cur_hdr_reg.size) + (OFF_W+1)'(HEADER_BYTES)
                    + (OFF_W+1)'(ram_rdata.size);

    // RAM port: one access per cycle chosen by the state
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = cur_reg;
        ram_wdata = cur_hdr_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready && s_data.kind == KIND_INIT) begin
                    ram_we    = 1'b1;
                    ram_addr  = '0;
                    ram_wdata = '{size: SIZE_CAP, next: '0, next_valid: 1'b0,
                                  free_mark: 1'b1};
                end else if (s_valid && s_ready && s_data.kind == KIND_FREE) begin
                    ram_addr = blk_off[OFF_W-1:0];
                end else begin
                    ram_addr = head_reg;
                end
            end
            S_A_SPLIT: begin
                ram_we    = 1'b1;
                ram_addr  = succ_reg;
                ram_wdata = '{size: cur_hdr_reg.size - SIZE_W'(req_reg)
                                    - SIZE_W'(HEADER_BYTES),
                              next: cur_hdr_reg.next,
                              next_valid: cur_hdr_reg.next_valid,
                              free_mark: 1'b1};
            end
            S_A_PREV: begin
                ram_we    = 1'b1;
                ram_addr  = prev_reg;
                ram_wdata = prev_hdr_reg;
                ram_wdata.next       = succ_reg;
                ram_wdata.next_valid = succ_valid_reg;
            end
            S_A_CUR: begin
                ram_we    = 1'b1;
                ram_wdata = '{size: cur_hdr_reg.size, next: '0, next_valid: 1'b0,
                              free_mark: 1'b0};
            end
            S_F_CHK: begin
                ram_we    = !ram_rdata.free_mark;
                ram_wdata = '{size: ram_rdata.size, next: head_reg,
                              next_valid: head_valid_reg, free_mark: 1'b1};
            end
            S_W_NRD: ram_addr = cur_hdr_reg.next;
            S_W_NCHK: begin
                ram_we    = 1'b1;
                ram_wdata = '{size: (merged > (OFF_W+1)'(SIZE_CAP)) ? SIZE_CAP
                                    : merged[SIZE_W-1:0],
                              next: ram_rdata.next,
                              next_valid: ram_rdata.next_valid,
                              free_mark: cur_hdr_reg.free_mark};
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid;
    assign m_data  = rsp_reg;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            m_valid        <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        rsp_reg.payload_offset <= '0;
                        req_reg       <= s_data.request_bytes;
                        cur_reg       <= (s_data.kind == KIND_FREE) ?
                                         blk_off[OFF_W-1:0] : head_reg;
                        have_prev_reg <= 1'b0;
                        steps_reg     <= '0;
                        case (s_data.kind)
                            KIND_INIT: begin
                                head_reg       <= '0;
                                head_valid_reg <= 1'b1;
                                rsp_reg.status <= ST_OK;
                                state_reg      <= S_RSP;
                            end
                            KIND_ALLOC: begin
                                if (s_data.request_bytes == '0) begin
                                    rsp_reg.status <= ST_ZERO;
                                    state_reg      <= S_RSP;
                                end else if (!head_valid_reg) begin
                                    rsp_reg.status <= ST_NO_FIT;
                                    state_reg      <= S_RSP;
                                end else begin
                                    rsp_reg.status <= ST_OK;
                                    state_reg      <= S_A_CHK;
                                end
                            end
                            KIND_FREE: begin
                                if (s_data.null_pointer) begin
                                    rsp_reg.status <= ST_NULL;
                                    state_reg      <= S_RSP;
                                end else if (blk_off < 0 ||
                                             blk_off >= 33'(HEAP_BYTES)) begin
                                    rsp_reg.status <= ST_INVALID;
                                    state_reg      <= S_RSP;
                                end else begin
                                    rsp_reg.status <= ST_OK;
                                    state_reg      <= S_F_CHK;
                                end
                            end
                            default: begin
                                rsp_reg.status <= ST_OK;
                                state_reg      <= S_RSP;
                            end
                        endcase
                    end
                end
                // Allocate: read issued for cur_reg
                S_A_RD: state_reg <= S_A_CHK;
                S_A_CHK: begin
                    cur_hdr_reg <= ram_rdata;
                    steps_reg   <= steps_reg + 1'b1;
                    if (ram_rdata.free_mark && 16'(ram_rdata.size) >= req_reg) begin
                        if (18'(ram_rdata.size) >= need && split_at < 18'(HEAP_BYTES)) begin
                            succ_reg       <= split_at[OFF_W-1:0];
                            succ_valid_reg <= 1'b1;
                            state_reg      <= S_A_SPLIT;
                        end else begin
                            succ_reg       <= ram_rdata.next;
                            succ_valid_reg <= ram_rdata.next_valid;
                            state_reg      <= have_prev_reg ? S_A_PREV : S_A_CUR;
                            if (!have_prev_reg) begin
                                head_reg       <= ram_rdata.next;
                                head_valid_reg <= ram_rdata.next_valid;
                            end
                        end
                    end else if (ram_rdata.next_valid &&
                                 steps_reg < STEP_W'(HEAP_BYTES - 1)) begin
                        prev_reg      <= cur_reg;
                        prev_hdr_reg  <= ram_rdata;
                        have_prev_reg <= 1'b1;
                        cur_reg       <= ram_rdata.next;
                        state_reg     <= S_A_RD;
                    end else begin
                        rsp_reg.status <= ST_NO_FIT;
                        state_reg      <= S_RSP;
                    end
                end
                S_A_SPLIT: begin
                    cur_hdr_reg.size <= SIZE_W'(req_reg);
                    if (have_prev_reg) begin
                        state_reg <= S_A_PREV;
                    end else begin
                        head_reg       <= succ_reg;
                        head_valid_reg <= 1'b1;
                        state_reg      <= S_A_CUR;
                    end
                end
                // predecessor keeps its own header, only its link changes
                S_A_PREV: state_reg <= S_A_CUR;
                S_A_CUR: begin
                    rsp_reg.payload_offset <= 14'(split_at - 18'(req_reg));
                    state_reg <= S_RSP;
                end
                // Free: header of the freed block arrives
                S_F_RD: state_reg <= S_F_CHK;
                S_F_CHK: begin
                    if (ram_rdata.free_mark) begin
                        rsp_reg.status <= ST_DOUBLE;
                        state_reg      <= S_RSP;
                    end else begin
                        head_reg       <= cur_reg;
                        head_valid_reg <= 1'b1;
                        state_reg      <= S_W_RD;
                    end
                end
                // Coalescing walk
                S_W_RD: state_reg <= S_W_CHK;
                S_W_CHK: begin
                    cur_hdr_reg <= ram_rdata;
                    steps_reg   <= steps_reg + 1'b1;
                    if (!ram_rdata.next_valid || steps_reg[STEP_W-1]) begin
                        state_reg <= S_RSP;
                    end else begin
                        state_reg <= S_W_NRD;
                    end
                end
                S_W_NRD: begin
                    if (end_at == 18'(cur_hdr_reg.next)) begin
                        state_reg <= S_W_NCHK;
                    end else begin
                        cur_reg   <= cur_hdr_reg.next;
                        state_reg <= S_W_RD;
                    end
                end
                S_W_NCHK: state_reg <= S_W_RD;
                S_RSP: begin
                    m_valid   <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks on the sequencer
    a_rsp_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == S_IDLE);
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE);
    a_write_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == S_IDLE) |-> (s_valid && s_ready));
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)));
endmodule
`default_nettype wire
